/* design/clab_pkg.sv */
// clab_pkg: shared types, widths, register indexes and defaults for the
// cell-list atom binning block. No dependencies.
`default_nettype none

package clab_pkg;

  localparam int CELLS_PER_AXIS_MAX_DEF = 16;
  localparam int SLOTS_PER_CELL_DEF     = 64;
  localparam int MIN_POPULATION         = 50;

  localparam int POS_W       = 24;
  localparam int INV_W       = 20;
  localparam int NCFG_W      = 5;
  localparam int CAP_W       = 7;
  localparam int SF_W        = 11;
  localparam int ID_W        = 16;
  localparam int CNT_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 20;
  localparam int PROD_W      = POS_W + INV_W;
  localparam int COORD_SHIFT = 34;
  localparam int OUT_COORD_W = 4;
  localparam int OUT_IDX_W   = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_INV_LEN_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_LEN_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_LEN_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SAFETY_Q8  = 3'd7;

  typedef logic [1:0] axis_t;
  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Y = 2'd1;
  localparam axis_t AXIS_Z = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_CLAMP,
    ST_IDX1,
    ST_IDX2,
    ST_READ,
    ST_UPDATE,
    ST_SCALE,
    ST_REPORT,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic  latch;
    logic  mul;
    logic  clamp;
    logic  idx1;
    logic  idx2;
    logic  read;
    logic  update;
    logic  scale;
    logic  report;
    logic  clear;
    axis_t axis;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
    logic clear_last;
  } dp_status_t;

endpackage

`default_nettype wire

/* design/clab_ctrl.sv */
// clab_ctrl: sequencer for the binning block (axis loop, index, count
// update, batch report, count clear). Depends on clab_pkg.
`default_nettype none

module clab_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire clab_pkg::dp_status_t   status,
  output clab_pkg::ctrl_cmd_t         cmd
);
  import clab_pkg::*;

  state_t state, state_next;
  axis_t  axis, axis_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      axis  <= AXIS_X;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

  always_comb begin
    state_next = state;
    axis_next  = axis;
    unique case (state)
      ST_IDLE: begin
        axis_next = AXIS_X;
        if (start) state_next = ST_MUL;
      end
      ST_MUL:    state_next = ST_CLAMP;
      ST_CLAMP: begin
        axis_next = axis + axis_t'(1);
        state_next = (axis == AXIS_Z) ? ST_IDX1 : ST_MUL;
      end
      ST_IDX1:   state_next = ST_IDX2;
      ST_IDX2:   state_next = ST_READ;
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: state_next = status.last ? ST_SCALE : ST_IDLE;
      ST_SCALE:  state_next = ST_REPORT;
      ST_REPORT: state_next = ST_CLEAR;
      ST_CLEAR:  if (status.clear_last) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.axis = axis;
    busy     = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      ST_MUL:    cmd.mul    = 1'b1;
      ST_CLAMP:  cmd.clamp  = 1'b1;
      ST_IDX1:   cmd.idx1   = 1'b1;
      ST_IDX2:   cmd.idx2   = 1'b1;
      ST_READ:   cmd.read   = 1'b1;
      ST_UPDATE: cmd.update = 1'b1;
      ST_SCALE:  cmd.scale  = 1'b1;
      ST_REPORT: cmd.report = 1'b1;
      ST_CLEAR:  cmd.clear  = 1'b1;
      default:   cmd        = '0;
    endcase
  end

endmodule

`default_nettype wire

/* design/clab_datapath.sv */
// clab_datapath: config registers, shared axis multiplier, cell index,
// count memory, id slot memory, peak tracking and result registers.
// Depends on clab_pkg.
`default_nettype none

module clab_datapath #(
  parameter int CELLS_PER_AXIS_MAX = clab_pkg::CELLS_PER_AXIS_MAX_DEF,
  parameter int SLOTS_PER_CELL     = clab_pkg::SLOTS_PER_CELL_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire clab_pkg::ctrl_cmd_t               cmd,
  output clab_pkg::dp_status_t                   status,
  input  wire logic                              cfg_write,
  input  wire logic [clab_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [clab_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic [clab_pkg::POS_W-1:0]        pos_x,
  input  wire logic [clab_pkg::POS_W-1:0]        pos_y,
  input  wire logic [clab_pkg::POS_W-1:0]        pos_z,
  input  wire logic [clab_pkg::ID_W-1:0]         atom_id,
  input  wire logic                              last_atom,
  output logic                                   done,
  output logic [clab_pkg::OUT_COORD_W-1:0]       cell_x,
  output logic [clab_pkg::OUT_COORD_W-1:0]       cell_y,
  output logic [clab_pkg::OUT_COORD_W-1:0]       cell_z,
  output logic [clab_pkg::OUT_IDX_W-1:0]         cell_index,
  output logic [clab_pkg::CNT_W-1:0]             slot,
  output logic                                   overflow,
  output logic [clab_pkg::CNT_W-1:0]             peak_count,
  output logic                                   resize_request,
  output logic [clab_pkg::CNT_W-1:0]             new_capacity
);
  import clab_pkg::*;

  localparam int NUM_CELLS = CELLS_PER_AXIS_MAX * CELLS_PER_AXIS_MAX * CELLS_PER_AXIS_MAX;
  localparam int CW   = (CELLS_PER_AXIS_MAX > 1) ? $clog2(CELLS_PER_AXIS_MAX) : 1;
  localparam int NW   = $clog2(CELLS_PER_AXIS_MAX + 1);
  localparam int IW   = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int SW   = $clog2(SLOTS_PER_CELL + 1);
  localparam int AW   = $clog2(NUM_CELLS * SLOTS_PER_CELL);
  localparam int CSW  = SW + SF_W;
  localparam int PSW  = CNT_W + SF_W;
  localparam int CMPW = PSW + 1;
  localparam int RAWC = PROD_W - COORD_SHIFT;
  localparam int SCW  = PSW - 8;

  function automatic logic [NW-1:0] eff_cells(input logic [NCFG_W-1:0] n);
    int unsigned v;
    v = 32'(n);
    if (v == 0) v = 1;
    if (v > 32'(CELLS_PER_AXIS_MAX)) v = 32'(CELLS_PER_AXIS_MAX);
    return NW'(v);
  endfunction

  // configuration
  logic [INV_W-1:0]  inv_len_x, inv_len_y, inv_len_z;
  logic [NCFG_W-1:0] cells_x, cells_y, cells_z;
  logic [CAP_W-1:0]  cell_capacity;
  logic [SF_W-1:0]   safety_factor_q8;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_len_x        <= INV_W'(131072);
      inv_len_y        <= INV_W'(131072);
      inv_len_z        <= INV_W'(131072);
      cells_x          <= NCFG_W'(16);
      cells_y          <= NCFG_W'(16);
      cells_z          <= NCFG_W'(16);
      cell_capacity    <= CAP_W'(64);
      safety_factor_q8 <= SF_W'(307);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_INV_LEN_X: inv_len_x        <= cfg_data[INV_W-1:0];
        CFG_INV_LEN_Y: inv_len_y        <= cfg_data[INV_W-1:0];
        CFG_INV_LEN_Z: inv_len_z        <= cfg_data[INV_W-1:0];
        CFG_CELLS_X:   cells_x          <= cfg_data[NCFG_W-1:0];
        CFG_CELLS_Y:   cells_y          <= cfg_data[NCFG_W-1:0];
        CFG_CELLS_Z:   cells_z          <= cfg_data[NCFG_W-1:0];
        CFG_CAPACITY:  cell_capacity    <= cfg_data[CAP_W-1:0];
        CFG_SAFETY_Q8: safety_factor_q8 <= cfg_data[SF_W-1:0];
        default: ;
      endcase
    end
  end

  logic [NW-1:0] nx_eff, ny_eff, nz_eff;
  logic [SW-1:0] cap_eff;

  always_comb begin
    nx_eff  = eff_cells(cells_x);
    ny_eff  = eff_cells(cells_y);
    nz_eff  = eff_cells(cells_z);
    cap_eff = (32'(cell_capacity) > 32'(SLOTS_PER_CELL)) ? SW'(SLOTS_PER_CELL)
                                                          : SW'(cell_capacity);
  end

  // latched request
  logic [POS_W-1:0] px, py, pz;
  logic [ID_W-1:0]  id_r;
  logic             last_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      px     <= pos_x;
      py     <= pos_y;
      pz     <= pos_z;
      id_r   <= atom_id;
      last_r <= last_atom;
    end
  end

  // shared axis multiplier and clamp
  logic [POS_W-1:0]  pos_sel;
  logic [INV_W-1:0]  inv_sel;
  logic [NW-1:0]     n_sel, lim;
  logic [PROD_W-1:0] prod;
  logic [RAWC-1:0]   raw_c;
  logic [CW-1:0]     coord_new;
  logic [CW-1:0]     cx, cy, cz;

  always_comb begin
    case (cmd.axis)
      AXIS_X:  begin pos_sel = px; inv_sel = inv_len_x; n_sel = nx_eff; end
      AXIS_Y:  begin pos_sel = py; inv_sel = inv_len_y; n_sel = ny_eff; end
      default: begin pos_sel = pz; inv_sel = inv_len_z; n_sel = nz_eff; end
    endcase
    lim       = n_sel - NW'(1);
    raw_c     = prod[PROD_W-1:COORD_SHIFT];
    coord_new = (raw_c > RAWC'(lim)) ? CW'(lim) : CW'(raw_c);
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) prod <= PROD_W'(pos_sel) * PROD_W'(inv_sel);
    if (cmd.clamp) begin
      case (cmd.axis)
        AXIS_X:  cx <= coord_new;
        AXIS_Y:  cy <= coord_new;
        default: cz <= coord_new;
      endcase
    end
  end

  // linear index
  logic [IW-1:0] idx_part, idx;

  always_ff @(posedge clk) begin
    if (cmd.idx1) idx_part <= IW'(cx) * IW'(ny_eff) + IW'(cy);
    if (cmd.idx2) idx      <= idx_part * IW'(nz_eff) + IW'(cz);
  end

  // count memory with clear sweep
  logic [CNT_W-1:0] cnt_mem [NUM_CELLS];
  logic [CNT_W-1:0] rd_cnt, cnt_inc;
  logic [IW-1:0]    clr_addr;
  logic             ovf;
  logic [CNT_W-1:0] running_peak, peak_next;
  logic [AW-1:0]    slot_addr;

  always_comb begin
    ovf       = rd_cnt >= CNT_W'(cap_eff);
    cnt_inc   = (rd_cnt == {CNT_W{1'b1}}) ? rd_cnt : rd_cnt + CNT_W'(1);
    peak_next = (cnt_inc > running_peak) ? cnt_inc : running_peak;
    slot_addr = AW'(idx) * AW'(SLOTS_PER_CELL) + AW'(rd_cnt);
    status.last       = last_r;
    status.clear_last = (clr_addr == IW'(NUM_CELLS - 1));
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      cnt_mem[clr_addr] <= '0;
    end else if (cmd.update) begin
      cnt_mem[idx] <= cnt_inc;
    end
    if (cmd.read) rd_cnt <= cnt_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear) begin
      clr_addr <= status.clear_last ? '0 : clr_addr + IW'(1);
    end
  end

  // id slot memory
  logic [ID_W-1:0] slot_mem [NUM_CELLS * SLOTS_PER_CELL];

  always_ff @(posedge clk) begin
    if (cmd.update && !ovf) slot_mem[slot_addr] <= id_r;
  end

  // peak and resize report
  logic [CSW-1:0]  cap_sf;
  logic [PSW-1:0]  peak_sf;
  logic            req;
  logic [SCW-1:0]  scaled;
  logic [CNT_W-1:0] newcap;

  always_comb begin
    req    = CMPW'({running_peak, 8'h00}) >= CMPW'(cap_sf);
    scaled = peak_sf[PSW-1:8];
    if (scaled < SCW'(MIN_POPULATION)) newcap = CNT_W'(MIN_POPULATION);
    else if (scaled > SCW'({CNT_W{1'b1}})) newcap = {CNT_W{1'b1}};
    else newcap = scaled[CNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_peak <= '0;
    end else if (cmd.update) begin
      running_peak <= peak_next;
    end else if (cmd.report) begin
      running_peak <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      cap_sf  <= CSW'(cap_eff) * CSW'(safety_factor_q8);
      peak_sf <= PSW'(running_peak) * PSW'(safety_factor_q8);
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.update && !last_r) || cmd.report;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      cell_x         <= OUT_COORD_W'(cx);
      cell_y         <= OUT_COORD_W'(cy);
      cell_z         <= OUT_COORD_W'(cz);
      cell_index     <= OUT_IDX_W'(idx);
      slot           <= rd_cnt;
      overflow       <= ovf;
      peak_count     <= '0;
      resize_request <= 1'b0;
      new_capacity   <= '0;
    end else if (cmd.report) begin
      peak_count     <= running_peak;
      resize_request <= req;
      new_capacity   <= req ? newcap : '0;
    end
  end

endmodule

`default_nettype wire

/* design/cell_list_atom_binning.sv */
// cell_list_atom_binning: top level, joins clab_ctrl and clab_datapath.
// Depends on clab_pkg, clab_ctrl, clab_datapath.
//
// channel   direction  handshake                 payload
// request   in         start && !busy            pos_x pos_y pos_z atom_id last_atom
// result    out        done (one cycle)          cell_x cell_y cell_z cell_index slot
//                                                overflow peak_count resize_request
//                                                new_capacity
// config    in         cfg_valid && cfg_ready    cfg_index cfg_data
//
// An atom goes from accept to its result through three multiply/clamp
// passes through the shared axis multiplier, two index steps, count read
// and count update. A last atom adds a scale and a report step and then a count
// clear sweep over all CELLS_PER_AXIS_MAX**3 cells (4096 by default), one cell a cycle.
// After reset the same sweep runs before the first request is taken.
// busy is low only when a request can be taken; the result cannot be stalled.
`default_nettype none

module cell_list_atom_binning #(
  parameter int CELLS_PER_AXIS_MAX = clab_pkg::CELLS_PER_AXIS_MAX_DEF,
  parameter int SLOTS_PER_CELL     = clab_pkg::SLOTS_PER_CELL_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [clab_pkg::POS_W-1:0]        pos_x,
  input  wire logic [clab_pkg::POS_W-1:0]        pos_y,
  input  wire logic [clab_pkg::POS_W-1:0]        pos_z,
  input  wire logic [clab_pkg::ID_W-1:0]         atom_id,
  input  wire logic                              last_atom,
  output logic                                   done,
  output logic [clab_pkg::OUT_COORD_W-1:0]       cell_x,
  output logic [clab_pkg::OUT_COORD_W-1:0]       cell_y,
  output logic [clab_pkg::OUT_COORD_W-1:0]       cell_z,
  output logic [clab_pkg::OUT_IDX_W-1:0]         cell_index,
  output logic [clab_pkg::CNT_W-1:0]             slot,
  output logic                                   overflow,
  output logic [clab_pkg::CNT_W-1:0]             peak_count,
  output logic                                   resize_request,
  output logic [clab_pkg::CNT_W-1:0]             new_capacity,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [clab_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [clab_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import clab_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  clab_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  clab_datapath #(
    .CELLS_PER_AXIS_MAX (CELLS_PER_AXIS_MAX),
    .SLOTS_PER_CELL     (SLOTS_PER_CELL)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_write      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pos_z          (pos_z),
    .atom_id        (atom_id),
    .last_atom      (last_atom),
    .done           (done),
    .cell_x         (cell_x),
    .cell_y         (cell_y),
    .cell_z         (cell_z),
    .cell_index     (cell_index),
    .slot           (slot),
    .overflow       (overflow),
    .peak_count     (peak_count),
    .resize_request (resize_request),
    .new_capacity   (new_capacity)
  );

endmodule

`default_nettype wire

/* design/clab_checker.sv */
// clab_checker: port-level assertions for cell_list_atom_binning, bound to
// the top level. Depends on clab_pkg.
`default_nettype none

module clab_checker #(
  parameter int SLOTS_PER_CELL = clab_pkg::SLOTS_PER_CELL_DEF
) (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic                              done,
  input wire logic                              overflow,
  input wire logic [clab_pkg::CNT_W-1:0]        slot,
  input wire logic [clab_pkg::CNT_W-1:0]        peak_count,
  input wire logic                              resize_request,
  input wire logic [clab_pkg::CNT_W-1:0]        new_capacity
);
  import clab_pkg::*;

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy low right after an accepted request");

  a_no_request_zero_cap: assert property (@(posedge clk) disable iff (rst)
    done && !resize_request |-> new_capacity == '0)
    else $error("new capacity without resize request");

  a_request_min_pop: assert property (@(posedge clk) disable iff (rst)
    done && resize_request |-> new_capacity >= CNT_W'(MIN_POPULATION) && peak_count != '0)
    else $error("resize request below minimum population");

  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    done && !overflow |-> 32'(slot) < 32'(SLOTS_PER_CELL))
    else $error("stored slot beyond cell slots");

endmodule

bind cell_list_atom_binning clab_checker #(
  .SLOTS_PER_CELL (SLOTS_PER_CELL)
) u_clab_checker (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .overflow       (overflow),
  .slot           (slot),
  .peak_count     (peak_count),
  .resize_request (resize_request),
  .new_capacity   (new_capacity)
);

`default_nettype wire
